### sv/afc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the box frustum culler
// Item layout, configuration write word and arithmetic widths.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int unsigned IDX_W     = 20;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned PLANE_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = COORD_W + NORM_W;
  localparam int unsigned ACC_W     = 53;
  localparam int unsigned OFF_SHIFT = 31;

  typedef struct packed {
    logic        [IDX_W-1:0]   index;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [COORD_W-1:0] size_x;
    logic        [COORD_W-1:0] size_y;
    logic        [COORD_W-1:0] size_z;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [PLANE_W-1:0]   data;
  } cfg_wr_t;

endpackage

### sv/aabb_frustum_cull_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core: streaming box culler against frustum planes
// Boxes pass a chain of plane cells; a box any plane rejects is dropped.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o  | instance_index_i, center_*_i, size_*_i
//  out     | out_valid_o / out_stall_i| kept_index_o, kept_center_*_o, kept_size_*_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One word per cycle while the output is not stalled; two register stages per
//  plane cell (products, then sum and sign test).
//  Reset clears all valid bits and all planes; zero planes pass every box.
//  Stall runs back through the cells; empty stages left by dropped words are
//  filled while the output is stalled.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core #(
  parameter int unsigned NUM_PLANES = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [afc_pkg::PLANE_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [afc_pkg::IDX_W-1:0]           instance_index_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_z_i,
  input  logic [afc_pkg::COORD_W-1:0]         size_x_i,
  input  logic [afc_pkg::COORD_W-1:0]         size_y_i,
  input  logic [afc_pkg::COORD_W-1:0]         size_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [afc_pkg::IDX_W-1:0]           kept_index_o,
  output logic signed [afc_pkg::COORD_W-1:0]  kept_center_x_o,
  output logic signed [afc_pkg::COORD_W-1:0]  kept_center_y_o,
  output logic signed [afc_pkg::COORD_W-1:0]  kept_center_z_o,
  output logic [afc_pkg::COORD_W-1:0]         kept_size_x_o,
  output logic [afc_pkg::COORD_W-1:0]         kept_size_y_o,
  output logic [afc_pkg::COORD_W-1:0]         kept_size_z_o
);

  afc_pkg::cfg_wr_t cfg_wr;
  logic             link_valid [NUM_PLANES+1];
  logic             link_stall [NUM_PLANES+1];
  afc_pkg::item_t   link_item  [NUM_PLANES+1];

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign link_valid[0]         = in_valid_i;
  assign in_stall_o            = link_stall[0];
  assign link_item[0].index    = instance_index_i;
  assign link_item[0].center_x = center_x_i;
  assign link_item[0].center_y = center_y_i;
  assign link_item[0].center_z = center_z_i;
  assign link_item[0].size_x   = size_x_i;
  assign link_item[0].size_y   = size_y_i;
  assign link_item[0].size_z   = size_z_i;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    afc_cell #(
      .CELL_IDX (p)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_i      (cfg_wr),
      .up_valid_i (link_valid[p]),
      .up_item_i  (link_item[p]),
      .up_stall_o (link_stall[p]),
      .dn_valid_o (link_valid[p+1]),
      .dn_item_o  (link_item[p+1]),
      .dn_stall_i (link_stall[p+1])
    );
  end

  assign link_stall[NUM_PLANES] = out_stall_i;
  assign out_valid_o            = link_valid[NUM_PLANES];
  assign kept_index_o           = link_item[NUM_PLANES].index;
  assign kept_center_x_o        = link_item[NUM_PLANES].center_x;
  assign kept_center_y_o        = link_item[NUM_PLANES].center_y;
  assign kept_center_z_o        = link_item[NUM_PLANES].center_z;
  assign kept_size_x_o          = link_item[NUM_PLANES].size_x;
  assign kept_size_y_o          = link_item[NUM_PLANES].size_y;
  assign kept_size_z_o          = link_item[NUM_PLANES].size_z;

endmodule

### sv/afc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_cell: one plane test cell
// Holds one plane, forms the per-axis products in a first stage, sums and
// tests the sign in a second, and drops the word when the plane rejects it.
// ----------------------------------------------------------------------------
module afc_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afc_pkg::cfg_wr_t cfg_i,
  input  logic             up_valid_i,
  input  afc_pkg::item_t   up_item_i,
  output logic             up_stall_o,
  output logic             dn_valid_o,
  output afc_pkg::item_t   dn_item_o,
  input  logic             dn_stall_i
);

  logic [afc_pkg::PLANE_W-1:0] plane_q;

  logic signed [afc_pkg::NORM_W-1:0] n_x, n_y, n_z, off;
  logic        [afc_pkg::NORM_W-1:0] m_x, m_y, m_z;

  logic                               s1_valid_q, s1_valid_d;
  afc_pkg::item_t                     s1_item_q;
  logic signed [afc_pkg::PROD_W-1:0]  pc_x_q, pc_y_q, pc_z_q;
  logic        [afc_pkg::PROD_W-1:0]  ps_x_q, ps_y_q, ps_z_q;
  logic signed [afc_pkg::PROD_W-1:0]  pc_x_d, pc_y_d, pc_z_d;
  logic        [afc_pkg::PROD_W-1:0]  ps_x_d, ps_y_d, ps_z_d;

  logic                               s2_valid_q, s2_valid_d;
  afc_pkg::item_t                     s2_item_q;
  logic signed [afc_pkg::ACC_W-1:0]   acc;
  logic                               rejects;
  logic                               s1_adv, s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_i.valid && cfg_i.index == afc_pkg::CFG_IDX_W'(CELL_IDX)) begin
      plane_q <= cfg_i.data;
    end
  end

  assign n_x = plane_q[15:0];
  assign n_y = plane_q[31:16];
  assign n_z = plane_q[47:32];
  assign off = plane_q[63:48];

  assign m_x = n_x[afc_pkg::NORM_W-1] ? (~n_x + 1'b1) : n_x;
  assign m_y = n_y[afc_pkg::NORM_W-1] ? (~n_y + 1'b1) : n_y;
  assign m_z = n_z[afc_pkg::NORM_W-1] ? (~n_z + 1'b1) : n_z;

  assign s2_adv     = !s2_valid_q || !dn_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign up_stall_o = !s1_adv;

  always_comb begin
    s1_valid_d = up_valid_i;
    pc_x_d = afc_pkg::PROD_W'(up_item_i.center_x) * afc_pkg::PROD_W'(n_x);
    pc_y_d = afc_pkg::PROD_W'(up_item_i.center_y) * afc_pkg::PROD_W'(n_y);
    pc_z_d = afc_pkg::PROD_W'(up_item_i.center_z) * afc_pkg::PROD_W'(n_z);
    ps_x_d = afc_pkg::PROD_W'(up_item_i.size_x) * afc_pkg::PROD_W'(m_x);
    ps_y_d = afc_pkg::PROD_W'(up_item_i.size_y) * afc_pkg::PROD_W'(m_y);
    ps_z_d = afc_pkg::PROD_W'(up_item_i.size_z) * afc_pkg::PROD_W'(m_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && up_valid_i) begin
      s1_item_q <= up_item_i;
      pc_x_q    <= pc_x_d;
      pc_y_q    <= pc_y_d;
      pc_z_q    <= pc_z_d;
      ps_x_q    <= ps_x_d;
      ps_y_q    <= ps_y_d;
      ps_z_q    <= ps_z_d;
    end
  end

  always_comb begin
    acc = (afc_pkg::ACC_W'(pc_x_q) <<< 1)
        + (afc_pkg::ACC_W'(pc_y_q) <<< 1)
        + (afc_pkg::ACC_W'(pc_z_q) <<< 1)
        + $signed(afc_pkg::ACC_W'(ps_x_q))
        + $signed(afc_pkg::ACC_W'(ps_y_q))
        + $signed(afc_pkg::ACC_W'(ps_z_q))
        + (afc_pkg::ACC_W'(off) <<< afc_pkg::OFF_SHIFT);
    rejects    = acc[afc_pkg::ACC_W-1];
    s2_valid_d = s1_valid_q && !rejects;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_item_q <= s1_item_q;
    end
  end

  assign dn_valid_o = s2_valid_q;
  assign dn_item_o  = s2_item_q;

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_adv && rejects |=> !s2_valid_q)
    else $error("rejected word reached the cell output");

  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_adv && !rejects |=> s2_valid_q && dn_item_o == $past(s1_item_q))
    else $error("passed word lost or changed in the cell");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_stall_o |-> s1_valid_q && s2_valid_q && dn_stall_i)
    else $error("cell stalls upstream while it has room");

endmodule

### test/aabb_frustum_cull_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core_tb: self-checking bench for the box frustum culler
// Loads plane sets through the config port and streams boxes with random
// gaps and output stalls. A local model predicts which boxes survive and
// every kept word is checked field by field, in order.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core_tb;

  localparam int NUM_PLANES     = 6;
  localparam int LATENCY        = 2 * NUM_PLANES;
  localparam int MAX_GAP        = 40;
  localparam int DRAIN_CYCLES   = 2 * LATENCY + MAX_GAP + 16;
  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_BOXES    = 110;

  localparam logic [15:0] Q14_ONE      = 16'h4000;
  localparam logic [15:0] Q14_NEG_ONE  = 16'hC000;
  localparam logic [15:0] Q14_MOST_NEG = 16'h8000;
  localparam logic [15:0] Q14_MAX      = 16'h7FFF;

  typedef enum logic [afc_pkg::CFG_IDX_W-1:0] {
    REG_PLANE_0, REG_PLANE_1, REG_PLANE_2, REG_PLANE_3,
    REG_PLANE_4, REG_PLANE_5, REG_SPARE_6, REG_SPARE_7
  } plane_reg_e;

  typedef enum int {
    SET_AXIS_BOX, SET_RANDOM, SET_SPARSE, SET_EXTREME
  } plane_set_e;

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          cfg_valid   = 1'b0;
  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [afc_pkg::PLANE_W-1:0]   cfg_data    = '0;
  logic                          cfg_ready;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  afc_pkg::item_t                in_word     = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  afc_pkg::item_t                kept_word;

  logic [afc_pkg::PLANE_W-1:0]   plane_cfg [NUM_PLANES];
  afc_pkg::item_t                box_feed [$];
  afc_pkg::item_t                visible_boxes [$];

  logic in_taken     = 1'b0;
  bit   in_no_gap    = 1'b0;
  bit   out_no_stall = 1'b0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   hold_req     = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;

  aabb_frustum_cull_core #(
    .NUM_PLANES(NUM_PLANES)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .instance_index_i(in_word.index),
    .center_x_i      (in_word.center_x),
    .center_y_i      (in_word.center_y),
    .center_z_i      (in_word.center_z),
    .size_x_i        (in_word.size_x),
    .size_y_i        (in_word.size_y),
    .size_z_i        (in_word.size_z),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kept_index_o    (kept_word.index),
    .kept_center_x_o (kept_word.center_x),
    .kept_center_y_o (kept_word.center_y),
    .kept_center_z_o (kept_word.center_z),
    .kept_size_x_o   (kept_word.size_x),
    .kept_size_y_o   (kept_word.size_y),
    .kept_size_z_o   (kept_word.size_z)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit plane_culls(input logic [afc_pkg::PLANE_W-1:0] p,
      input afc_pkg::item_t b);
    longint nrm [3];
    longint ctr [3];
    longint sz [3];
    longint acc;
    int     a;
    nrm[0] = longint'($signed(p[15:0]));
    nrm[1] = longint'($signed(p[31:16]));
    nrm[2] = longint'($signed(p[47:32]));
    ctr[0] = longint'($signed(b.center_x));
    ctr[1] = longint'($signed(b.center_y));
    ctr[2] = longint'($signed(b.center_z));
    sz[0]  = longint'({32'd0, b.size_x});
    sz[1]  = longint'({32'd0, b.size_y});
    sz[2]  = longint'({32'd0, b.size_z});
    acc    = longint'($signed(p[63:48])) <<< afc_pkg::OFF_SHIFT;
    for (a = 0; a < 3; a++) begin
      acc += 2 * (ctr[a] * nrm[a]);
      acc += sz[a] * ((nrm[a] < 0) ? -nrm[a] : nrm[a]);
    end
    return acc < 0;
  endfunction

  function automatic bit box_visible(input afc_pkg::item_t b);
    int i;
    for (i = 0; i < NUM_PLANES; i++) begin
      if (plane_culls(plane_cfg[i], b)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [afc_pkg::PLANE_W-1:0] pack_plane(input logic [15:0] nx,
      input logic [15:0] ny, input logic [15:0] nz, input logic [15:0] off);
    return {off, nz, ny, nx};
  endfunction

  function automatic logic signed [31:0] wu(input int v);
    return v <<< 16;
  endfunction

  function automatic afc_pkg::item_t mk_box(input logic [19:0] idx,
      input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
      input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz);
    afc_pkg::item_t b;
    b.index    = idx;
    b.center_x = cx;
    b.center_y = cy;
    b.center_z = cz;
    b.size_x   = sx;
    b.size_y   = sy;
    b.size_z   = sz;
    return b;
  endfunction

  function automatic logic [31:0] near_coord(input int span);
    return wu(int'($urandom_range(0, 2 * span)) - span) + $urandom_range(0, 65535);
  endfunction

  function automatic afc_pkg::item_t near_box(input int span, input int size_span);
    return mk_box(20'($urandom_range(0, 20'hFFFFF)),
                  near_coord(span), near_coord(span), near_coord(span),
                  $urandom_range(0, size_span << 16), $urandom_range(0, size_span << 16),
                  $urandom_range(0, size_span << 16));
  endfunction

  function automatic afc_pkg::item_t noise_box();
    return mk_box(20'($urandom_range(0, 20'hFFFFF)), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, MAX_GAP);
  endfunction

  function automatic logic [afc_pkg::PLANE_W-1:0] extreme_plane();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return pack_plane(Q14_MAX, Q14_MAX, Q14_MAX, Q14_MAX);
      3:       return pack_plane(Q14_MOST_NEG, Q14_MOST_NEG, Q14_MOST_NEG, Q14_MOST_NEG);
      4:       return pack_plane(Q14_MOST_NEG, Q14_MAX, Q14_MOST_NEG, Q14_MAX);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (box_feed.size() != 0) begin
        in_word  <= box_feed.pop_front();
        in_valid <= 1'b1;
        gap_left = (in_no_gap || $urandom_range(0, 1)) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if (!out_no_stall && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end
  end

  // predict on accepted input, check accepted output, watch for hangs
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall && box_visible(in_word)) visible_boxes.push_back(in_word);
      if (out_valid && !out_stall) begin
        if (visible_boxes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word idx=%h c=%h %h %h s=%h %h %h", $time,
                     kept_word.index, kept_word.center_x, kept_word.center_y,
                     kept_word.center_z, kept_word.size_x, kept_word.size_y,
                     kept_word.size_z);
        end else begin
          afc_pkg::item_t exp_box;
          exp_box = visible_boxes.pop_front();
          if (kept_word.index !== exp_box.index ||
              kept_word.center_x !== exp_box.center_x ||
              kept_word.center_y !== exp_box.center_y ||
              kept_word.center_z !== exp_box.center_z ||
              kept_word.size_x !== exp_box.size_x ||
              kept_word.size_y !== exp_box.size_y ||
              kept_word.size_z !== exp_box.size_z) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp idx=%h c=%h %h %h s=%h %h %h", $time,
                       exp_box.index, exp_box.center_x, exp_box.center_y,
                       exp_box.center_z, exp_box.size_x, exp_box.size_y, exp_box.size_z);
              $display("%0t:          got idx=%h c=%h %h %h s=%h %h %h", $time,
                       kept_word.index, kept_word.center_x, kept_word.center_y,
                       kept_word.center_z, kept_word.size_x, kept_word.size_y,
                       kept_word.size_z);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input plane_reg_e idx, input logic [afc_pkg::PLANE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_PLANE_5) plane_cfg[idx] = data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every word is through and dropped boxes have left the pipe
  task automatic wait_idle();
    while (box_feed.size() != 0 || in_valid || visible_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int         phase;
    int         i;
    int         span;
    int         size_span;
    int         half [3];
    plane_set_e set;

    for (i = 0; i < NUM_PLANES; i++) plane_cfg[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset planes: everything passes
    box_feed.push_back(mk_box(20'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    box_feed.push_back(mk_box(20'hFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    box_feed.push_back(mk_box(20'h0, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h0, 32'h0, 32'h0));
    box_feed.push_back(mk_box(20'hAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                              32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
    box_feed.push_back(mk_box(20'h55555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                              32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    wait_idle();

    // axis box of half width 100; spare indexes get a cull-all plane
    write_reg(REG_PLANE_0, pack_plane(Q14_ONE, 16'h0, 16'h0, 16'd100));
    write_reg(REG_PLANE_1, pack_plane(Q14_NEG_ONE, 16'h0, 16'h0, 16'd100));
    write_reg(REG_PLANE_2, pack_plane(16'h0, Q14_ONE, 16'h0, 16'd100));
    write_reg(REG_PLANE_3, pack_plane(16'h0, Q14_NEG_ONE, 16'h0, 16'd100));
    write_reg(REG_PLANE_4, pack_plane(16'h0, 16'h0, Q14_ONE, 16'd100));
    write_reg(REG_PLANE_5, pack_plane(16'h0, 16'h0, Q14_NEG_ONE, 16'd100));
    write_reg(REG_SPARE_6, pack_plane(16'h0, 16'h0, 16'h0, 16'hFFFF));
    write_reg(REG_SPARE_7, pack_plane(16'h0, 16'h0, 16'h0, 16'hFFFF));
    end_writes();
    box_feed.push_back(mk_box(20'h1, 32'h0, 32'h0, 32'h0, wu(1), wu(1), wu(1)));
    box_feed.push_back(mk_box(20'h2, wu(150), 32'h0, 32'h0, wu(2), wu(2), wu(2)));
    box_feed.push_back(mk_box(20'h3, wu(150), 32'h0, 32'h0, wu(100), wu(2), wu(2)));
    box_feed.push_back(mk_box(20'h4, wu(150), 32'h0, 32'h0, wu(100) - 1, wu(2), wu(2)));
    box_feed.push_back(mk_box(20'h5, 32'h0, wu(-150), 32'h0, wu(2), wu(2), wu(2)));
    box_feed.push_back(mk_box(20'h6, 32'h0, 32'h0, wu(150), wu(2), wu(2), wu(2)));
    box_feed.push_back(mk_box(20'h7, wu(-100), 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    box_feed.push_back(mk_box(20'h8, wu(30000), 32'h0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0));
    wait_idle();

    // extreme planes: most negative normals, offset limits, all ones
    write_reg(REG_PLANE_0, pack_plane(Q14_MOST_NEG, Q14_MOST_NEG, Q14_MOST_NEG, Q14_MAX));
    write_reg(REG_PLANE_1, '1);
    write_reg(REG_PLANE_2, pack_plane(Q14_MAX, Q14_MAX, Q14_MAX, Q14_MOST_NEG));
    write_reg(REG_PLANE_3, '0);
    write_reg(REG_PLANE_4, pack_plane(Q14_MOST_NEG, 16'h0, 16'h0, 16'h0));
    write_reg(REG_PLANE_5, '0);
    end_writes();
    box_feed.push_back(mk_box(20'h9, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    box_feed.push_back(mk_box(20'hA, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h0, 32'h0, 32'h0));
    box_feed.push_back(mk_box(20'hB, 32'h0, 32'h0, 32'h0,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    box_feed.push_back(mk_box(20'hC, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              32'h0, 32'h0, 32'h0));
    box_feed.push_back(mk_box(20'hD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    wait_idle();

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      set = plane_set_e'(phase % 4);
      for (i = 0; i < 3; i++) half[i] = $urandom_range(1, 2000);
      span      = $urandom_range(1, 30000);
      size_span = $urandom_range(0, 30000);
      for (i = 0; i < NUM_PLANES; i++) begin
        case (set)
          SET_AXIS_BOX: begin
            write_reg(plane_reg_e'(REG_PLANE_0 + i),
                      pack_plane((i / 2 == 0) ? ((i % 2) ? Q14_NEG_ONE : Q14_ONE) : 16'h0,
                                 (i / 2 == 1) ? ((i % 2) ? Q14_NEG_ONE : Q14_ONE) : 16'h0,
                                 (i / 2 == 2) ? ((i % 2) ? Q14_NEG_ONE : Q14_ONE) : 16'h0,
                                 16'(half[i / 2])));
          end
          SET_RANDOM: write_reg(plane_reg_e'(REG_PLANE_0 + i), {$urandom, $urandom});
          SET_SPARSE: write_reg(plane_reg_e'(REG_PLANE_0 + i),
                                $urandom_range(0, 1) ? {$urandom, $urandom} : '0);
          default:    write_reg(plane_reg_e'(REG_PLANE_0 + i), extreme_plane());
        endcase
      end
      if ($urandom_range(0, 1))
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
      end_writes();
      if (set == SET_AXIS_BOX) begin
        span      = 3 * ((half[0] > half[1]) ? half[0] : half[1]) / 2 + 3 * half[2] / 4;
        size_span = (half[0] + half[1] + half[2]) / 3;
      end
      in_no_gap    = (phase % 3 == 1) || phase == 4 || phase == 8;
      out_no_stall = (phase % 5 == 2);
      if (phase == 4 || phase == 8) hold_req++;
      for (i = 0; i < PHASE_BOXES; i++)
        box_feed.push_back(($urandom_range(0, 4) == 0) ? noise_box() : near_box(span, size_span));
      wait_idle();
    end

    if (mismatches == 0 && visible_boxes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/afc_pkg.sv
sv/afc_cell.sv
sv/aabb_frustum_cull_core.sv
test/aabb_frustum_cull_core_tb.sv
